/* hw/rtl/els_pkg.sv */
// Shared types and constants of the LOOK elevator scheduler.
`default_nettype none

package els_pkg;

    localparam int FLOOR_W    = 5;
    localparam int COUNT_W    = 8;
    localparam int CAP_W      = 8;
    localparam int PEND_W     = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 3;

    localparam logic [FLOOR_W-1:0] MIN_FLOOR_RESET = 5'd0;
    localparam logic [FLOOR_W-1:0] MAX_FLOOR_RESET = 5'd31;
    localparam logic [CAP_W-1:0]   CAPACITY_RESET  = 8'd8;

    typedef enum logic [1:0] {
        CMD_REQUEST = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_BOARD   = 2'd2,
        CMD_EXIT    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_REFUSED   = 3'd2,
        ST_OVER_EXIT = 3'd3,
        ST_ZERO      = 3'd4
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_FLOOR = 2'd0,
        CFG_MAX_FLOOR = 2'd1,
        CFG_CAPACITY  = 2'd2
    } cfg_addr_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [FLOOR_W-1:0] floor;
        logic [COUNT_W-1:0] count;
    } item_t;

    typedef struct packed {
        logic [FLOOR_W-1:0] min_floor;
        logic [FLOOR_W-1:0] max_floor;
        logic [CAP_W-1:0]   capacity;
    } cfg_t;

    typedef struct packed {
        status_t            status;
        logic [FLOOR_W-1:0] car_floor;
        dir_t               direction;
        logic [COUNT_W-1:0] load;
        logic [PEND_W-1:0]  pending;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/els_look.sv */
// LOOK direction chooser: keep heading while stops lie ahead, else reverse or pick nearer.
`default_nettype none

module els_look #(
    parameter int STOP_W = 32
) (
    input  wire logic [STOP_W-1:0]          stops_above,
    input  wire logic [STOP_W-1:0]          stops_below,
    input  wire logic [els_pkg::FLOOR_W-1:0] floor_now,
    input  wire els_pkg::dir_t              heading,
    output els_pkg::dir_t                   heading_new
);

    logic                         any_up;
    logic                         any_down;
    logic [els_pkg::FLOOR_W-1:0]  lowest_above;
    logic [els_pkg::FLOOR_W-1:0]  highest_below;
    logic [els_pkg::FLOOR_W-1:0]  up_dist;
    logic [els_pkg::FLOOR_W-1:0]  down_dist;

    assign any_up   = |stops_above;
    assign any_down = |stops_below;

    // priority encoders: last hit wins, so scan order picks lowest / highest
    always_comb begin
        lowest_above = '0;
        for (int i = STOP_W - 1; i >= 0; i--) begin
            if (stops_above[i]) begin
                lowest_above = els_pkg::FLOOR_W'(i);
            end
        end
    end

    always_comb begin
        highest_below = '0;
        for (int i = 0; i < STOP_W; i++) begin
            if (stops_below[i]) begin
                highest_below = els_pkg::FLOOR_W'(i);
            end
        end
    end

    // stops above always sit above the car and stops below under it
    assign up_dist   = lowest_above - floor_now;
    assign down_dist = floor_now - highest_below;

    always_comb begin
        priority if (heading == els_pkg::DIR_UP && any_up) begin
            heading_new = els_pkg::DIR_UP;
        end else if (heading == els_pkg::DIR_DOWN && any_down) begin
            heading_new = els_pkg::DIR_DOWN;
        end else if (heading == els_pkg::DIR_UP && any_down) begin
            heading_new = els_pkg::DIR_DOWN;
        end else if (heading == els_pkg::DIR_DOWN && any_up) begin
            heading_new = els_pkg::DIR_UP;
        end else if (any_up && any_down) begin
            // idle with work both ways: nearer stop, ties go up
            heading_new = (up_dist <= down_dist) ? els_pkg::DIR_UP : els_pkg::DIR_DOWN;
        end else if (any_up) begin
            heading_new = els_pkg::DIR_UP;
        end else if (any_down) begin
            heading_new = els_pkg::DIR_DOWN;
        end else begin
            heading_new = els_pkg::DIR_IDLE;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/els_core.sv */
// Car state registers and the combinational command update.
`default_nettype none

module els_core #(
    parameter int NUM_FLOORS = 32
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire els_pkg::item_t  item,
    input  wire els_pkg::cfg_t   cfg,
    output els_pkg::result_t     result
);

    // only floors reachable through a 5-bit request need a stop bit
    localparam int STOP_W = (NUM_FLOORS > 32) ? 32 : NUM_FLOORS;
    localparam logic [els_pkg::PEND_W-1:0] FLOOR_LIMIT = els_pkg::PEND_W'(NUM_FLOORS);

    logic [els_pkg::FLOOR_W-1:0] floor_reg,   floor_next;
    els_pkg::dir_t               dir_reg,     dir_next;
    logic [STOP_W-1:0]           above_reg,   above_next;
    logic [STOP_W-1:0]           below_reg,   below_next;
    logic [els_pkg::COUNT_W-1:0] load_reg,    load_next;
    logic [els_pkg::PEND_W-1:0]  pending_reg, pending_next;

    logic                        req_ok;
    logic [STOP_W-1:0]           tgt_mask;
    logic [STOP_W-1:0]           up_mask;
    logic [STOP_W-1:0]           down_mask;
    logic [STOP_W-1:0]           above_filed;
    logic [STOP_W-1:0]           below_filed;
    logic [els_pkg::PEND_W-1:0]  pend_filed;
    logic [els_pkg::FLOOR_W-1:0] floor_up;
    logic [els_pkg::FLOOR_W-1:0] floor_down;
    logic [els_pkg::COUNT_W:0]   board_sum;
    els_pkg::dir_t               look_dir;
    els_pkg::status_t            status;

    assign req_ok = (item.floor >= cfg.min_floor) && (item.floor <= cfg.max_floor)
                    && ({2'b00, item.floor} < FLOOR_LIMIT);
    assign floor_up   = floor_reg + 5'd1;
    assign floor_down = floor_reg - 5'd1;
    assign board_sum  = {1'b0, load_reg} + {1'b0, item.count};

    always_comb begin
        for (int i = 0; i < STOP_W; i++) begin
            tgt_mask[i]  = (els_pkg::FLOOR_W'(i) == item.floor);
            up_mask[i]   = (els_pkg::FLOOR_W'(i) == floor_up);
            down_mask[i] = (els_pkg::FLOOR_W'(i) == floor_down);
        end
    end

    // stop bitmaps with a valid request filed; the look chooser sees these
    always_comb begin
        above_filed = above_reg;
        below_filed = below_reg;
        pend_filed  = pending_reg;
        if (item.cmd == els_pkg::CMD_REQUEST && req_ok) begin
            if (item.floor > floor_reg) begin
                above_filed = above_reg | tgt_mask;
                pend_filed  = pending_reg + els_pkg::PEND_W'(~|(above_reg & tgt_mask));
            end else if (item.floor < floor_reg) begin
                below_filed = below_reg | tgt_mask;
                pend_filed  = pending_reg + els_pkg::PEND_W'(~|(below_reg & tgt_mask));
            end
        end
    end

    els_look #(
        .STOP_W (STOP_W)
    ) u_look (
        .stops_above (above_filed),
        .stops_below (below_filed),
        .floor_now   (floor_reg),
        .heading     (dir_reg),
        .heading_new (look_dir)
    );

    always_comb begin
        floor_next   = floor_reg;
        dir_next     = dir_reg;
        above_next   = above_reg;
        below_next   = below_reg;
        load_next    = load_reg;
        pending_next = pending_reg;
        status       = els_pkg::ST_OK;
        unique case (item.cmd)
            els_pkg::CMD_REQUEST: begin
                if (!req_ok) begin
                    status = els_pkg::ST_RANGE;
                end else begin
                    above_next   = above_filed;
                    below_next   = below_filed;
                    pending_next = pend_filed;
                    dir_next     = look_dir;
                end
            end
            els_pkg::CMD_TICK: begin
                if (look_dir == els_pkg::DIR_UP && (|above_reg || |below_reg)) begin
                    floor_next   = floor_up;
                    above_next   = above_reg & ~up_mask;
                    pending_next = pending_reg - els_pkg::PEND_W'(|(above_reg & up_mask));
                    if (|above_next) begin
                        dir_next = els_pkg::DIR_UP;
                    end else begin
                        dir_next = (|below_reg) ? els_pkg::DIR_DOWN : els_pkg::DIR_IDLE;
                    end
                end else if (look_dir == els_pkg::DIR_DOWN && (|above_reg || |below_reg)) begin
                    floor_next   = floor_down;
                    below_next   = below_reg & ~down_mask;
                    pending_next = pending_reg - els_pkg::PEND_W'(|(below_reg & down_mask));
                    if (|below_next) begin
                        dir_next = els_pkg::DIR_DOWN;
                    end else begin
                        dir_next = (|above_reg) ? els_pkg::DIR_UP : els_pkg::DIR_IDLE;
                    end
                end
            end
            els_pkg::CMD_BOARD: begin
                if (item.count == '0) begin
                    status = els_pkg::ST_ZERO;
                end else if (board_sum > {1'b0, cfg.capacity}) begin
                    status = els_pkg::ST_REFUSED;
                end else begin
                    load_next = board_sum[els_pkg::COUNT_W-1:0];
                end
            end
            els_pkg::CMD_EXIT: begin
                if (item.count == '0) begin
                    status = els_pkg::ST_ZERO;
                end else if (item.count > load_reg) begin
                    status = els_pkg::ST_OVER_EXIT;
                end else begin
                    load_next = load_reg - item.count;
                end
            end
        endcase
    end

    always_comb begin
        result.status    = status;
        result.car_floor = floor_next;
        result.direction = dir_next;
        result.load      = load_next;
        result.pending   = pending_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg   <= '0;
            dir_reg     <= els_pkg::DIR_IDLE;
            above_reg   <= '0;
            below_reg   <= '0;
            load_reg    <= '0;
            pending_reg <= '0;
        end else if (step) begin
            floor_reg   <= floor_next;
            dir_reg     <= dir_next;
            above_reg   <= above_next;
            below_reg   <= below_next;
            load_reg    <= load_next;
            pending_reg <= pending_next;
        end
    end

    // running stop count must track the bitmaps
    a_pending_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(above_reg) + $countones(below_reg)) == int'(pending_reg))
        else $error("pending stop count out of step with bitmaps");

    a_idle_iff_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (dir_reg == els_pkg::DIR_IDLE) == (pending_reg == '0))
        else $error("heading idle does not match empty stop set");

    a_up_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (dir_reg == els_pkg::DIR_UP) |-> (|above_reg))
        else $error("heading up with no stop above");

    a_one_floor_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && floor_reg != $past(floor_reg)) |->
        (floor_reg == $past(floor_reg) + 5'd1 || floor_reg == $past(floor_reg) - 5'd1))
        else $error("car moved more than one floor");

endmodule

`default_nettype wire

/* hw/rtl/elevator_look_scheduler.sv */
// Top level: stream ports, config registers, input and result registers.
// Each request passes the input register, els_core and the result register in turn.
// Throughput: one request per cycle while m_ is not stalled.
// A stalled result register holds; the input register keeps accepting while it can drain.
// Reset (aresetn low, synchronous): car at floor 0, idle, no stops, empty car,
// min_floor 0, max_floor 31, car_capacity 8; ready again once aresetn is high.
`default_nettype none

module elevator_look_scheduler #(
    parameter int NUM_FLOORS = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // requests
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [els_pkg::S_TDATA_W-1:0]    s_tdata,   // floor[4:0], count[12:5]
    input  wire logic [els_pkg::S_TUSER_W-1:0]    s_tuser,   // cmd[1:0]
    // results
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // car_floor[4:0], direction[6:5], load[14:7], pending_stops[21:15]
    output logic [els_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic [els_pkg::M_TUSER_W-1:0]         m_tuser,   // status[2:0]
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [els_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [els_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic               in_valid_reg,  in_valid_next;
    els_pkg::item_t     item_reg;
    logic               out_valid_reg, out_valid_next;
    els_pkg::result_t   out_reg;
    els_pkg::cfg_t      cfg_reg,       cfg_next;
    els_pkg::result_t   core_result;
    logic               step;
    logic               take;

    // nothing is taken while reset is held
    assign step      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = aresetn && (!in_valid_reg || step);
    assign take      = s_tvalid && s_tready;
    assign cfg_ready = aresetn;

    always_comb begin
        in_valid_next = take ? 1'b1 : (step ? 1'b0 : in_valid_reg);
        out_valid_next = step ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_addr)
                els_pkg::CFG_MIN_FLOOR: cfg_next.min_floor = cfg_data[els_pkg::FLOOR_W-1:0];
                els_pkg::CFG_MAX_FLOOR: cfg_next.max_floor = cfg_data[els_pkg::FLOOR_W-1:0];
                els_pkg::CFG_CAPACITY:  cfg_next.capacity  = cfg_data[els_pkg::CAP_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            cfg_reg.min_floor  <= els_pkg::MIN_FLOOR_RESET;
            cfg_reg.max_floor  <= els_pkg::MAX_FLOOR_RESET;
            cfg_reg.capacity   <= els_pkg::CAPACITY_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.cmd   <= els_pkg::cmd_t'(s_tuser);
            item_reg.floor <= s_tdata[4:0];
            item_reg.count <= s_tdata[12:5];
        end
        if (step) begin
            out_reg <= core_result;
        end
    end

    els_core #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {2'b00, out_reg.pending, out_reg.load, out_reg.direction,
                       out_reg.car_floor};

endmodule

`default_nettype wire

/* bench/car_report_checker.sv */
// Checker for the elevator scheduler: predicts each result from accepted requests and compares.
`timescale 1ns / 1ps

module car_report_checker #(
    parameter int NUM_FLOORS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [els_pkg::S_TDATA_W-1:0]   s_tdata,   // floor[4:0], count[12:5]
    input  wire logic [els_pkg::S_TUSER_W-1:0]   s_tuser,   // cmd[1:0]
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    // car_floor[4:0], direction[6:5], load[14:7], pending_stops[21:15]
    input  wire logic [els_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic [els_pkg::M_TUSER_W-1:0]   m_tuser,   // status[2:0]
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [els_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [els_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                   fail_count,
    output int                                   reports_due
);

    // predicted car state and register copies
    logic [els_pkg::FLOOR_W-1:0] floor_now;
    els_pkg::dir_t               heading;
    logic [31:0]                 stops_up;
    logic [31:0]                 stops_down;
    logic [els_pkg::COUNT_W-1:0] riders;
    logic [els_pkg::FLOOR_W-1:0] lo_floor;
    logic [els_pkg::FLOOR_W-1:0] hi_floor;
    logic [els_pkg::CAP_W-1:0]   capacity;

    els_pkg::result_t car_reports_q[$];

    function automatic int lowest_stop(logic [31:0] map);
        for (int i = 0; i < 32; i++)
            if (map[i]) return i;
        return 0;
    endfunction

    function automatic int highest_stop(logic [31:0] map);
        for (int i = 31; i >= 0; i--)
            if (map[i]) return i;
        return 0;
    endfunction

    // LOOK: keep going while stops lie ahead, else reverse; from idle go to the nearer side
    function automatic void pick_heading();
        logic        go_up;
        logic        go_down;
        logic [31:0] up_gap;
        logic [31:0] down_gap;
        go_up   = |stops_up;
        go_down = |stops_down;
        if (heading == els_pkg::DIR_UP && go_up) return;
        if (heading == els_pkg::DIR_DOWN && go_down) return;
        if (heading == els_pkg::DIR_UP && go_down) begin
            heading = els_pkg::DIR_DOWN;
            return;
        end
        if (heading == els_pkg::DIR_DOWN && go_up) begin
            heading = els_pkg::DIR_UP;
            return;
        end
        if (go_up && go_down) begin
            up_gap   = 32'(lowest_stop(stops_up)) - 32'(floor_now);
            down_gap = 32'(floor_now) - 32'(highest_stop(stops_down));
            heading  = (up_gap <= down_gap) ? els_pkg::DIR_UP : els_pkg::DIR_DOWN;
        end else if (go_up) begin
            heading = els_pkg::DIR_UP;
        end else if (go_down) begin
            heading = els_pkg::DIR_DOWN;
        end else begin
            heading = els_pkg::DIR_IDLE;
        end
    endfunction

    function automatic void move_car();
        if (stops_up == '0 && stops_down == '0) return;
        pick_heading();
        if (heading == els_pkg::DIR_UP) begin
            floor_now = floor_now + 1'b1;
            stops_up[floor_now] = 1'b0;
            if (stops_up == '0)
                heading = (stops_down != '0) ? els_pkg::DIR_DOWN : els_pkg::DIR_IDLE;
        end else if (heading == els_pkg::DIR_DOWN) begin
            floor_now = floor_now - 1'b1;
            stops_down[floor_now] = 1'b0;
            if (stops_down == '0)
                heading = (stops_up != '0) ? els_pkg::DIR_UP : els_pkg::DIR_IDLE;
        end
    endfunction

    function automatic els_pkg::result_t run_command(els_pkg::item_t req);
        els_pkg::result_t rep;
        els_pkg::status_t st;
        st = els_pkg::ST_OK;
        case (req.cmd)
            els_pkg::CMD_REQUEST: begin
                if (req.floor < lo_floor || req.floor > hi_floor
                    || int'(req.floor) >= NUM_FLOORS) begin
                    st = els_pkg::ST_RANGE;
                end else begin
                    if (req.floor > floor_now) stops_up[req.floor] = 1'b1;
                    else if (req.floor < floor_now) stops_down[req.floor] = 1'b1;
                    pick_heading();
                end
            end
            els_pkg::CMD_TICK: move_car();
            els_pkg::CMD_BOARD: begin
                if (req.count == '0) st = els_pkg::ST_ZERO;
                else if (9'(riders) + 9'(req.count) > 9'(capacity)) st = els_pkg::ST_REFUSED;
                else riders = riders + req.count;
            end
            default: begin
                if (req.count == '0) st = els_pkg::ST_ZERO;
                else if (req.count > riders) st = els_pkg::ST_OVER_EXIT;
                else riders = riders - req.count;
            end
        endcase
        rep.status    = st;
        rep.car_floor = floor_now;
        rep.direction = heading;
        rep.load      = riders;
        rep.pending   = els_pkg::PEND_W'($countones(stops_up | stops_down));
        return rep;
    endfunction

    task automatic flag(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        els_pkg::item_t   req;
        els_pkg::result_t got;
        els_pkg::result_t want;
        if (!aresetn) begin
            floor_now  = '0;
            heading    = els_pkg::DIR_IDLE;
            stops_up   = '0;
            stops_down = '0;
            riders     = '0;
            lo_floor   = els_pkg::MIN_FLOOR_RESET;
            hi_floor   = els_pkg::MAX_FLOOR_RESET;
            capacity   = els_pkg::CAPACITY_RESET;
            fail_count = 0;
            car_reports_q.delete();
        end else begin
            // result first: it can only belong to a request from an earlier edge
            if (m_tvalid && m_tready) begin
                got.status    = els_pkg::status_t'(m_tuser[2:0]);
                got.car_floor = m_tdata[4:0];
                got.direction = els_pkg::dir_t'(m_tdata[6:5]);
                got.load      = m_tdata[14:7];
                got.pending   = m_tdata[21:15];
                if (car_reports_q.size() == 0) begin
                    $display("%0t: result with none expected, actual status %0d floor %0d",
                             $time, got.status, got.car_floor);
                    fail_count++;
                end else begin
                    want = car_reports_q.pop_front();
                    flag("status", want.status, got.status);
                    flag("car_floor", want.car_floor, got.car_floor);
                    flag("direction", want.direction, got.direction);
                    flag("load", want.load, got.load);
                    flag("pending_stops", want.pending, got.pending);
                end
            end
            if (s_tvalid && s_tready) begin
                req.cmd   = els_pkg::cmd_t'(s_tuser);
                req.floor = s_tdata[4:0];
                req.count = s_tdata[12:5];
                car_reports_q.insert(car_reports_q.size(), run_command(req));
            end
            if (cfg_valid && cfg_ready) begin
                case (els_pkg::cfg_addr_t'(cfg_addr))
                    els_pkg::CFG_MIN_FLOOR: lo_floor = cfg_data[els_pkg::FLOOR_W-1:0];
                    els_pkg::CFG_MAX_FLOOR: hi_floor = cfg_data[els_pkg::FLOOR_W-1:0];
                    els_pkg::CFG_CAPACITY:  capacity = cfg_data[els_pkg::CAP_W-1:0];
                    default: ;
                endcase
            end
        end
        reports_due <= car_reports_q.size();
    end

endmodule

/* bench/tb.sv */
// Testbench top: drives requests and register writes into the scheduler and gives the verdict.
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AFTER  = 400;    // results taken before the long receiver hold
    localparam int HOLD_CYCLES = 300;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [els_pkg::S_TDATA_W-1:0]  s_tdata   = '0;  // floor[4:0], count[12:5]
    logic [els_pkg::S_TUSER_W-1:0]  s_tuser   = '0;  // cmd[1:0]
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    // car_floor[4:0], direction[6:5], load[14:7], pending[21:15]
    logic [els_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [els_pkg::M_TUSER_W-1:0]  m_tuser;         // status[2:0]
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [els_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [els_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int reports_due;

    // current register settings, used to shape the stimulus
    int cur_min = 0;
    int cur_max = 31;
    int cur_cap = 8;
    bit burst   = 1'b0;

    elevator_look_scheduler #(.NUM_FLOORS(32)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    car_report_checker #(.NUM_FLOORS(32)) report_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .fail_count(fail_count), .reports_due(reports_due)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic els_pkg::item_t pack_item(els_pkg::cmd_t c, int f, int n);
        els_pkg::item_t it;
        it.cmd   = c;
        it.floor = els_pkg::FLOOR_W'(f);
        it.count = els_pkg::COUNT_W'(n);
        return it;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // mostly served floors, ticks to move the car, and small loads; some raw noise
    function automatic els_pkg::item_t random_item();
        els_pkg::item_t it;
        int             r;
        int             top;
        r        = $urandom_range(0, 99);
        it.floor = els_pkg::FLOOR_W'($urandom_range(0, 31));
        it.count = els_pkg::COUNT_W'($urandom_range(0, 255));
        if (r < 35) begin
            it.cmd = els_pkg::CMD_REQUEST;
            if (cur_min <= cur_max && $urandom_range(0, 9) != 0)
                it.floor = els_pkg::FLOOR_W'($urandom_range(cur_min, cur_max));
        end else if (r < 70) begin
            it.cmd = els_pkg::CMD_TICK;
        end else begin
            it.cmd = (r < 85) ? els_pkg::CMD_BOARD : els_pkg::CMD_EXIT;
            top = (cur_cap > 4) ? cur_cap : 4;
            r = $urandom_range(0, 19);
            if (r < 12) it.count = els_pkg::COUNT_W'($urandom_range(1, 4));
            else if (r < 17) it.count = els_pkg::COUNT_W'($urandom_range(1, top));
        end
        return it;
    endfunction

    task automatic play(els_pkg::item_t it);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.count, it.floor};
        s_tuser  <= it.cmd;
        do @(posedge aclk); while (!s_tready);
        gap = burst ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic random_items(int n);
        repeat (n) play(random_item());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (reports_due != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(int lo, int hi, int cap);
        els_pkg::cfg_addr_t idx [3];
        int                 val [3];
        drain();
        cur_min = lo;
        cur_max = hi;
        cur_cap = cap;
        idx = '{els_pkg::CFG_MIN_FLOOR, els_pkg::CFG_MAX_FLOOR, els_pkg::CFG_CAPACITY};
        val = '{lo, hi, cap};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_data  <= els_pkg::CFG_DATA_W'(val[i]);
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // result receiver: random ready runs, plus one long hold while the sender keeps pushing
    initial begin
        int  run;
        int  taken;
        bit  held;
        taken = 0;
        held  = 1'b0;
        forever begin
            if (!held && taken >= HOLD_AFTER) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                held = 1'b1;
            end else begin
                if ($urandom_range(0, 99) < 60) begin
                    m_tready <= 1'b1;
                    run = $urandom_range(1, 30);
                end else begin
                    m_tready <= 1'b0;
                    run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
                end
                repeat (run) begin
                    @(posedge aclk);
                    if (m_tvalid && m_tready) taken++;
                end
            end
        end
    end

    // watchdog: ends the run when no channel has moved for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("elevator_look_scheduler verification failed");
        $finish;
    end

    initial begin
        els_pkg::item_t opening[$];
        int             lo;
        int             hi;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: errors, full car, reversal with stops behind, top floor
        opening = '{
            pack_item(els_pkg::CMD_REQUEST, 0, 0),  pack_item(els_pkg::CMD_TICK, 31, 255),
            pack_item(els_pkg::CMD_BOARD, 0, 0),    pack_item(els_pkg::CMD_EXIT, 0, 0),
            pack_item(els_pkg::CMD_EXIT, 0, 1),     pack_item(els_pkg::CMD_BOARD, 0, 8),
            pack_item(els_pkg::CMD_BOARD, 0, 1),    pack_item(els_pkg::CMD_EXIT, 0, 8),
            pack_item(els_pkg::CMD_BOARD, 0, 255),  pack_item(els_pkg::CMD_EXIT, 0, 255),
            pack_item(els_pkg::CMD_REQUEST, 2, 0),  pack_item(els_pkg::CMD_TICK, 0, 0),
            pack_item(els_pkg::CMD_TICK, 0, 0),     pack_item(els_pkg::CMD_REQUEST, 4, 0),
            pack_item(els_pkg::CMD_REQUEST, 0, 0),  pack_item(els_pkg::CMD_TICK, 0, 0),
            pack_item(els_pkg::CMD_REQUEST, 3, 0),  pack_item(els_pkg::CMD_TICK, 0, 0),
            pack_item(els_pkg::CMD_TICK, 0, 0),     pack_item(els_pkg::CMD_TICK, 0, 0),
            pack_item(els_pkg::CMD_TICK, 0, 0),     pack_item(els_pkg::CMD_TICK, 0, 0),
            pack_item(els_pkg::CMD_REQUEST, 31, 0)
        };
        foreach (opening[i]) play(opening[i]);
        random_items(220);

        configure(0, 31, 255);
        burst = 1'b1;
        random_items(220);
        burst = 1'b0;

        configure(3, 20, 8);
        play(pack_item(els_pkg::CMD_REQUEST, 2, 0));
        play(pack_item(els_pkg::CMD_REQUEST, 21, 0));
        play(pack_item(els_pkg::CMD_REQUEST, 0, 0));
        play(pack_item(els_pkg::CMD_REQUEST, 31, 0));
        play(pack_item(els_pkg::CMD_REQUEST, 3, 0));
        play(pack_item(els_pkg::CMD_REQUEST, 20, 0));
        random_items(220);

        configure(31, 31, 1);
        random_items(100);
        configure(0, 0, 0);     // zero capacity refuses every nonzero boarding
        random_items(100);
        configure(12, 5, 20);   // inverted range rejects every request
        random_items(100);

        repeat (4) begin
            lo = $urandom_range(0, 31);
            hi = $urandom_range(lo, 31);
            configure(lo, hi, $urandom_range(1, 255));
            burst = ($urandom_range(0, 3) == 0);
            random_items(220);
        end

        burst = 1'b0;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (reports_due != 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("elevator_look_scheduler verification clean");
        else
            $display("elevator_look_scheduler verification failed");
        $finish;
    end

endmodule

/* elevator_look_scheduler.f */
hw/rtl/els_pkg.sv
hw/rtl/els_look.sv
hw/rtl/els_core.sv
hw/rtl/elevator_look_scheduler.sv
bench/car_report_checker.sv
bench/tb.sv
